/* src/assert_macros.svh */
// ============================================================================
// Assertion macros
// Concurrent assertion shorthands used by the RPN evaluator back end.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RPN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RPN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rpn_pkg.sv */
// ============================================================================
// rpn_pkg
// Types, character codes and sizes shared by the RPN evaluator modules.
// ============================================================================
package rpn_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int DATA_W          = 32;
    localparam int CHAR_W          = 8;
    localparam int DIGIT_W         = 4;
    localparam int CMD_Q_DEPTH     = 2;
    localparam int DIV_STEPS       = DATA_W;

    // ASCII codes the classifier looks for.
    localparam logic [CHAR_W-1:0] CHR_AMP   = 8'h26;
    localparam logic [CHAR_W-1:0] CHR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHR_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CHR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CHR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_LF    = 8'h66;

    // Value of the hex letter A.
    localparam logic [DIGIT_W-1:0] HEX_LETTER_BASE = 4'd10;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNDER   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_OVER    = 2'd3
    } t_status;

    // Character classes handed from the front end to the back end.
    typedef enum logic [3:0] {
        K_IGNORE,
        K_DIGIT,
        K_HEXLET,
        K_AMP,
        K_SPACE,
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV
    } t_kind;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
    } t_out_item;

    typedef struct packed {
        t_kind              kind;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_TOP,
        S_RD_BOT,
        S_EXEC,
        S_DIV,
        S_FIN
    } t_state;

endpackage

/* src/rpn_front.sv */
// ============================================================================
// rpn_front
// Accepts characters, classifies them and holds one classified command.
// ============================================================================
module rpn_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_vld,
    output logic               o_in_stall,
    input  rpn_pkg::t_in_item  i_in_data,
    output logic               o_cmd_vld,
    input  logic               i_cmd_stall,
    output rpn_pkg::t_cmd      o_cmd
);

    logic [rpn_pkg::CHAR_W-1:0] w_ch;
    rpn_pkg::t_cmd              w_cmd;
    logic                       w_load;
    logic                       r_vld;
    logic                       n_vld;
    rpn_pkg::t_cmd              r_cmd;

    assign w_ch = i_in_data.character;

    // Sort the character into a command class and a digit value.
    always_comb begin
        w_cmd.kind  = rpn_pkg::K_IGNORE;
        w_cmd.digit = '0;
        w_cmd.last  = i_in_data.last_char;
        priority if (w_ch >= rpn_pkg::CHR_0 && w_ch <= rpn_pkg::CHR_9) begin
            w_cmd.kind  = rpn_pkg::K_DIGIT;
            w_cmd.digit = rpn_pkg::DIGIT_W'(w_ch - rpn_pkg::CHR_0);
        end else if (w_ch >= rpn_pkg::CHR_UA && w_ch <= rpn_pkg::CHR_UF) begin
            w_cmd.kind  = rpn_pkg::K_HEXLET;
            w_cmd.digit = rpn_pkg::DIGIT_W'(w_ch - rpn_pkg::CHR_UA)
                          + rpn_pkg::HEX_LETTER_BASE;
        end else if (w_ch >= rpn_pkg::CHR_LA && w_ch <= rpn_pkg::CHR_LF) begin
            w_cmd.kind  = rpn_pkg::K_HEXLET;
            w_cmd.digit = rpn_pkg::DIGIT_W'(w_ch - rpn_pkg::CHR_LA)
                          + rpn_pkg::HEX_LETTER_BASE;
        end else if (w_ch == rpn_pkg::CHR_AMP) begin
            w_cmd.kind = rpn_pkg::K_AMP;
        end else if (w_ch == rpn_pkg::CHR_SPACE) begin
            w_cmd.kind = rpn_pkg::K_SPACE;
        end else if (w_ch == rpn_pkg::CHR_PLUS) begin
            w_cmd.kind = rpn_pkg::K_ADD;
        end else if (w_ch == rpn_pkg::CHR_MINUS) begin
            w_cmd.kind = rpn_pkg::K_SUB;
        end else if (w_ch == rpn_pkg::CHR_STAR) begin
            w_cmd.kind = rpn_pkg::K_MUL;
        end else if (w_ch == rpn_pkg::CHR_SLASH) begin
            w_cmd.kind = rpn_pkg::K_DIV;
        end else begin
            w_cmd.kind = rpn_pkg::K_IGNORE;
        end
    end

    // One-entry output stage toward the command queue.
    assign o_in_stall = r_vld && i_cmd_stall;
    assign w_load     = i_in_vld && !o_in_stall;
    assign n_vld      = w_load || (r_vld && i_cmd_stall);
    assign o_cmd_vld  = r_vld;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

/* src/rpn_cmd_fifo.sv */
// ============================================================================
// rpn_cmd_fifo
// Short command queue that decouples the front end from the back end.
// ============================================================================
module rpn_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_vld,
    output logic           o_push_stall,
    input  rpn_pkg::t_cmd  i_push_data,
    output logic           o_pop_vld,
    input  logic           i_pop,
    output rpn_pkg::t_cmd  o_pop_data
);

    localparam int PTR_W = $clog2(rpn_pkg::CMD_Q_DEPTH);
    localparam int CNT_W = $clog2(rpn_pkg::CMD_Q_DEPTH + 1);

    rpn_pkg::t_cmd    r_mem [rpn_pkg::CMD_Q_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_push_stall = (r_cnt == CNT_W'(rpn_pkg::CMD_Q_DEPTH));
    assign o_pop_vld    = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_vld && !o_push_stall;
    assign w_pop        = i_pop && o_pop_vld;

    // Pointer wrap and fill count.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(rpn_pkg::CMD_Q_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(rpn_pkg::CMD_Q_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        unique case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

/* src/rpn_divider.sv */
// ============================================================================
// rpn_divider
// Signed 32-bit divider, one restoring quotient bit per cycle.
// ============================================================================
module rpn_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rpn_pkg::DATA_W-1:0] i_dividend,
    input  logic [rpn_pkg::DATA_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [rpn_pkg::DATA_W-1:0] o_quotient
);

    localparam int DW    = rpn_pkg::DATA_W;
    localparam int CNT_W = $clog2(rpn_pkg::DIV_STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_quo;
    logic [DW-1:0]    r_div;
    logic             r_neg;
    logic [DW-1:0]    r_out;
    logic [DW:0]      w_shift;
    logic [DW:0]      w_diff;
    logic             w_fits;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign w_shift = {r_rem, r_quo[DW-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_fits  = !w_diff[DW];

    assign o_done     = r_done;
    assign o_quotient = r_out;

    // Control: busy flag, step count and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(rpn_pkg::DIV_STEPS);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: operand magnitudes, shift steps and final sign fix.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[DW-1] ? (DW'(0) - i_dividend) : i_dividend;
            r_div <= i_divisor[DW-1] ? (DW'(0) - i_divisor) : i_divisor;
            r_neg <= i_dividend[DW-1] ^ i_divisor[DW-1];
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_rem <= w_fits ? w_diff[DW-1:0] : w_shift[DW-1:0];
                r_quo <= {r_quo[DW-2:0], w_fits};
            end else begin
                r_out <= r_neg ? (DW'(0) - r_quo) : r_quo;
            end
        end
    end

endmodule

/* src/rpn_back.sv */
// ============================================================================
// rpn_back
// Executes classified commands on the value stack and produces results.
// ============================================================================
`include "assert_macros.svh"

module rpn_back #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_vld,
    output logic               o_cmd_pop,
    input  rpn_pkg::t_cmd      i_cmd,
    output logic               o_out_vld,
    input  logic               i_out_stall,
    output rpn_pkg::t_out_item o_out_data
);

    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam int DW   = rpn_pkg::DATA_W;

    // Stack memory holds finished entries below the stack pointer.
    logic [DW-1:0]      r_mem [STACK_DEPTH];
    logic [DW-1:0]      r_rdata;
    logic               w_we;
    logic [SP_W-1:0]    w_waddr;
    logic [SP_W-1:0]    w_raddr;
    logic [DW-1:0]      w_wdata;

    rpn_pkg::t_state    r_state;
    rpn_pkg::t_state    n_state;
    logic [SP_W-1:0]    r_sp;
    logic [SP_W-1:0]    n_sp;
    logic [DW-1:0]      r_acc;
    logic [DW-1:0]      n_acc;
    logic [DW-1:0]      r_bottom;
    logic [DW-1:0]      n_bottom;
    logic [DW-1:0]      r_top;
    logic [DW-1:0]      n_top;
    logic [DW-1:0]      r_bot;
    logic [DW-1:0]      n_bot;
    logic               r_started;
    logic               n_started;
    logic               r_hex;
    logic               n_hex;
    rpn_pkg::t_status   r_err;
    rpn_pkg::t_status   n_err;
    rpn_pkg::t_cmd      r_cmd;
    rpn_pkg::t_cmd      n_cmd;
    logic               r_out_vld;
    logic               n_out_vld;
    rpn_pkg::t_out_item r_out;
    rpn_pkg::t_out_item n_out;

    logic [DW-1:0]      w_dec_acc;
    logic [DW-1:0]      w_hex_acc;
    logic [DW-1:0]      w_prod;
    logic [DW-1:0]      w_res;
    logic               w_wb;
    logic               w_div_start;
    logic               w_div_done;
    logic [DW-1:0]      w_div_quot;

    // Digit accumulation: times ten as two shifts, times sixteen as one.
    assign w_dec_acc = (r_acc << 3) + (r_acc << 1) + DW'(i_cmd.digit);
    assign w_hex_acc = {r_acc[DW-rpn_pkg::DIGIT_W-1:0], i_cmd.digit};
    assign w_prod    = r_bot * r_top;

    assign o_out_vld  = r_out_vld;
    assign o_out_data = r_out;

    rpn_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_bot),
        .i_divisor  (r_top),
        .o_done     (w_div_done),
        .o_quotient (w_div_quot)
    );

    // Stack memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Sequencer: next state, stack updates and result loading.
    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_acc       = r_acc;
        n_bottom    = r_bottom;
        n_top       = r_top;
        n_bot       = r_bot;
        n_started   = r_started;
        n_hex       = r_hex;
        n_err       = r_err;
        n_cmd       = r_cmd;
        n_out_vld   = r_out_vld && i_out_stall;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_sp;
        w_wdata     = r_acc;
        w_raddr     = r_sp - SP_W'(1);
        w_div_start = 1'b0;
        w_wb        = 1'b0;
        w_res       = r_bot + r_top;

        unique case (r_state)
            rpn_pkg::S_IDLE: begin
                if (i_cmd_vld) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = i_cmd.last ? rpn_pkg::S_FIN : rpn_pkg::S_IDLE;
                    if (r_err == rpn_pkg::ST_OK) begin
                        unique case (i_cmd.kind)
                            rpn_pkg::K_AMP: begin
                                if (!r_started) begin
                                    n_started = 1'b1;
                                    n_hex     = 1'b1;
                                end
                            end
                            rpn_pkg::K_DIGIT: begin
                                n_acc     = r_hex ? w_hex_acc : w_dec_acc;
                                n_started = 1'b1;
                            end
                            rpn_pkg::K_HEXLET: begin
                                if (r_hex) begin
                                    n_acc     = w_hex_acc;
                                    n_started = 1'b1;
                                end
                            end
                            rpn_pkg::K_SPACE: begin
                                // Push the number being built.
                                if (r_started) begin
                                    if (r_sp == SP_W'(STACK_DEPTH - 1)) begin
                                        n_err = rpn_pkg::ST_OVER;
                                    end else begin
                                        w_we = 1'b1;
                                        if (r_sp == '0) begin
                                            n_bottom = r_acc;
                                        end
                                        n_sp  = r_sp + SP_W'(1);
                                        n_acc = '0;
                                    end
                                end
                            end
                            rpn_pkg::K_ADD, rpn_pkg::K_SUB,
                            rpn_pkg::K_MUL, rpn_pkg::K_DIV: begin
                                n_started = 1'b0;
                                n_hex     = 1'b0;
                                if (r_sp < SP_W'(2)) begin
                                    n_err = rpn_pkg::ST_UNDER;
                                end else begin
                                    n_state = rpn_pkg::S_RD_TOP;
                                end
                            end
                            rpn_pkg::K_IGNORE: begin
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            rpn_pkg::S_RD_TOP: begin
                n_top   = r_rdata;
                w_raddr = r_sp - SP_W'(2);
                n_state = rpn_pkg::S_RD_BOT;
            end
            rpn_pkg::S_RD_BOT: begin
                n_bot   = r_rdata;
                n_state = rpn_pkg::S_EXEC;
            end
            rpn_pkg::S_EXEC: begin
                n_state = r_cmd.last ? rpn_pkg::S_FIN : rpn_pkg::S_IDLE;
                unique case (r_cmd.kind)
                    rpn_pkg::K_ADD: begin
                        w_res = r_bot + r_top;
                        w_wb  = 1'b1;
                    end
                    rpn_pkg::K_SUB: begin
                        w_res = r_bot - r_top;
                        w_wb  = 1'b1;
                    end
                    rpn_pkg::K_MUL: begin
                        w_res = w_prod;
                        w_wb  = 1'b1;
                    end
                    rpn_pkg::K_DIV: begin
                        if (r_top == '0) begin
                            n_err = rpn_pkg::ST_DIVZERO;
                        end else begin
                            w_div_start = 1'b1;
                            n_state     = rpn_pkg::S_DIV;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            rpn_pkg::S_DIV: begin
                if (w_div_done) begin
                    w_res   = w_div_quot;
                    w_wb    = 1'b1;
                    n_state = r_cmd.last ? rpn_pkg::S_FIN : rpn_pkg::S_IDLE;
                end
            end
            rpn_pkg::S_FIN: begin
                // Load the result once the output register is free, then start over.
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld    = 1'b1;
                    n_out.value  = (r_err == rpn_pkg::ST_OK)
                                   ? $signed((r_sp == '0) ? r_acc : r_bottom) : '0;
                    n_out.status = r_err;
                    n_sp         = '0;
                    n_acc        = '0;
                    n_started    = 1'b0;
                    n_hex        = 1'b0;
                    n_err        = rpn_pkg::ST_OK;
                    n_state      = rpn_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rpn_pkg::S_IDLE;
            end
        endcase

        // Operator write-back: two entries become one, new number starts at zero.
        if (w_wb) begin
            w_we    = 1'b1;
            w_waddr = r_sp - SP_W'(2);
            w_wdata = w_res;
            if (r_sp == SP_W'(2)) begin
                n_bottom = w_res;
            end
            n_sp  = r_sp - SP_W'(1);
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rpn_pkg::S_IDLE;
            r_sp      <= '0;
            r_acc     <= '0;
            r_started <= 1'b0;
            r_hex     <= 1'b0;
            r_err     <= rpn_pkg::ST_OK;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sp      <= n_sp;
            r_acc     <= n_acc;
            r_started <= n_started;
            r_hex     <= n_hex;
            r_err     <= n_err;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bottom <= n_bottom;
        r_top    <= n_top;
        r_bot    <= n_bot;
        r_cmd    <= n_cmd;
        r_out    <= n_out;
    end

    // Checks on the sequencer.
    `RPN_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, w_div_start, r_top != '0, "divider started with zero divisor")
    `RPN_ASSERT_IMP(a_pop_depth, i_clk, i_rst_n, r_state == rpn_pkg::S_RD_TOP, r_sp >= SP_W'(2), "operator read with fewer than two entries")
    `RPN_ASSERT_IMP(a_err_value, i_clk, i_rst_n, r_out_vld && (r_out.status != rpn_pkg::ST_OK), r_out.value == '0, "error result carries a nonzero value")
    `RPN_ASSERT_NXT(a_fin_clears, i_clk, i_rst_n, (r_state == rpn_pkg::S_FIN) && !r_out_vld, r_out_vld && (r_sp == '0) && (r_err == rpn_pkg::ST_OK), "result load did not restart the evaluator")
    `RPN_ASSERT_NXT(a_err_sticky, i_clk, i_rst_n, (r_err != rpn_pkg::ST_OK) && (r_state != rpn_pkg::S_FIN), r_err == $past(r_err), "error code changed before the result")

endmodule

/* src/rpn_expression_evaluator_core.sv */
// ============================================================================
// rpn_expression_evaluator_core
// Postfix integer expression evaluator fed one character per item.
// ============================================================================
//
//  Channel  Dir  Handshake                  Payload
//  in       in   i_in_vld / o_in_stall      rpn_pkg::t_in_item  (character, last_char)
//  out      out  o_out_vld / i_out_stall    rpn_pkg::t_out_item (value, status)
//
// Digits, '&', spaces and ignored characters are handled in the back-end idle state; + - *
// pass through two reads of the stack memory's single read port and an execute state.
// '/' also waits in a divide state while the 32-step divider runs.
// The item marked last then passes through a state that loads the result register.
// Synchronous active-low reset clears the sequencer, flags and queue; the stack memory
// needs no clearing pass since only entries written in the current expression are read.
// A front register and a two-entry command queue keep taking items, until they are full,
// while the back end works or waits for a stalled result to be taken.
module rpn_expression_evaluator_core #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_vld,
    output logic               o_in_stall,
    input  rpn_pkg::t_in_item  i_in_data,
    output logic               o_out_vld,
    input  logic               i_out_stall,
    output rpn_pkg::t_out_item o_out_data
);

    logic          w_fe_vld;
    logic          w_q_full;
    rpn_pkg::t_cmd w_fe_cmd;
    logic          w_q_vld;
    logic          w_q_pop;
    rpn_pkg::t_cmd w_q_cmd;

    // Front end: classify characters.
    rpn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_vld    (i_in_vld),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_cmd_vld   (w_fe_vld),
        .i_cmd_stall (w_q_full),
        .o_cmd       (w_fe_cmd)
    );

    // Command queue between the two halves.
    rpn_cmd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_vld   (w_fe_vld),
        .o_push_stall (w_q_full),
        .i_push_data  (w_fe_cmd),
        .o_pop_vld    (w_q_vld),
        .i_pop        (w_q_pop),
        .o_pop_data   (w_q_cmd)
    );

    // Back end: stack execution and result output.
    rpn_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_vld   (w_q_vld),
        .o_cmd_pop   (w_q_pop),
        .i_cmd       (w_q_cmd),
        .o_out_vld   (o_out_vld),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
